>>> src/sprite_frame_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// Sprite frame sequencer: assertion macros
// Shared wrappers for concurrent assertions, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_CORE_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and codes shared by the sprite frame sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfs_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned PRI_W      = 8;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned RUN_W      = 2;
  localparam int unsigned ACCUM_W    = 32;
  localparam int unsigned LOOP_W     = 2;
  localparam int unsigned FCOUNT_W   = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Request types
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CMD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONTINUE = 3'd4;

  // Run states
  localparam logic [RUN_W-1:0] RUN_PAUSED = 2'd0;
  localparam logic [RUN_W-1:0] RUN_INC    = 2'd1;
  localparam logic [RUN_W-1:0] RUN_DEC    = 2'd2;

  // Loop modes; the unused code behaves as stop at end
  localparam logic [LOOP_W-1:0] LOOP_STOP   = 2'd0;
  localparam logic [LOOP_W-1:0] LOOP_REPEAT = 2'd1;
  localparam logic [LOOP_W-1:0] LOOP_PING   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_CMP  = 5'b00100,
    S_RD   = 5'b01000,
    S_RES  = 5'b10000
  } seq_state_e;

endpackage

>>> src/sfs_ram.sv
// ----------------------------------------------------------------------------
// sfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/sprite_frame_sequencer_core.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_core
// Sprite animation frame sequencer with a frame duration table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_* channel (valid/ready). Each request is a tick,
//   a command or a duration load, picked by req_type_i, and gives exactly one
//   result on the out_* channel: current frame, run state, applied flag.
//   The cfg_* channel writes wrap_mode (index 0) and frame_count (index 1);
//   it is always ready and is meant to be written while the block is idle.
// Sequence:
//   Commands, loads and paused ticks go straight to the result state; a
//   new request is taken only once the previous result is loaded.
//   Running ticks add the scaled time, then step N frames (N at most
//   MAX_ADVANCE) before the result. Each step is a read of the
//   duration RAM (registered read data) and a compare/subtract/step.
// Reset:
//   Time 0, frame 0, paused, resume increasing, priority 0, speed 1.0,
//   repeat mode, one frame. The duration table is not cleared; load every
//   entry the animation uses before running it.
// Stall:
//   A finished result waits in the output register; the core keeps taking
//   requests and holds only when a second result is ready while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_frame_sequencer_core #(
  parameter int unsigned MAX_FRAMES  = 64,
  parameter int unsigned MAX_ADVANCE = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sfs_pkg::REQ_W-1:0]    req_type_i,
  input  logic [sfs_pkg::DELTA_W-1:0]  delta_time_i,
  input  logic [sfs_pkg::CMD_W-1:0]    command_i,
  input  logic [sfs_pkg::PRI_W-1:0]    priority_req_i,
  input  logic                         speed_change_i,
  input  logic [sfs_pkg::SPEED_W-1:0]  new_speed_i,
  input  logic [sfs_pkg::FRAME_W-1:0]  load_index_i,
  input  logic [sfs_pkg::DUR_W-1:0]    load_duration_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfs_pkg::FRAME_W-1:0]  frame_index_o,
  output logic [sfs_pkg::RUN_W-1:0]    run_state_o,
  output logic                         applied_o,
  // configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import sfs_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_ADVANCE + 1);

  seq_state_e state_q, state_d;

  // configuration
  logic [LOOP_W-1:0]   wrap_mode_q;
  logic [FCOUNT_W-1:0] frame_count_q;

  // sequencer state
  logic [ACCUM_W-1:0] accum_q, accum_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [RUN_W-1:0]   mode_q, mode_d;
  logic [RUN_W-1:0]   resume_q, resume_d;
  logic [PRI_W-1:0]   prio_q, prio_d;
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic               applied_q, applied_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ACCUM_W-1:0] prod_q;

  // output register
  logic               out_valid_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [RUN_W-1:0]   out_run_q;
  logic               out_applied_q;
  logic               out_load;

  logic in_fire;
  logic ram_we;
  logic [DUR_W-1:0] ram_rdata;
  logic [DUR_W-1:0] dur;
  logic             frame_in_table;

  logic [FCOUNT_W-1:0] fc_eff;
  logic [FCOUNT_W-1:0] last;
  logic [FRAME_W-1:0]  step_frame;
  logic [RUN_W-1:0]    step_mode;
  logic [ACCUM_W:0]    sum;
  logic                cmd_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Duration table. Reads follow frame_q every cycle; the registered data is used
  // in S_CMP in the next cycle, while frame_q has not moved.
  // --------------------------------------------------------------------------
  assign ram_we = in_fire && (req_type_i == REQ_LOAD) && (32'(load_index_i) < MAX_FRAMES);

  sfs_ram #(
    .WIDTH (DUR_W),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (load_duration_i),
    .raddr_i (AW'(frame_q)),
    .rdata_o (ram_rdata)
  );

  // Frames past the table read as zero duration.
  assign frame_in_table = (32'(frame_q) < MAX_FRAMES);
  assign dur            = frame_in_table ? ram_rdata : '0;

  // --------------------------------------------------------------------------
  // Last frame: a count of zero acts as one, a count past the table as the
  // table size.
  // --------------------------------------------------------------------------
  always_comb begin
    if (frame_count_q == '0) begin
      fc_eff = FCOUNT_W'(1);
    end else if (32'(frame_count_q) > MAX_FRAMES) begin
      fc_eff = FCOUNT_W'(MAX_FRAMES);
    end else begin
      fc_eff = frame_count_q;
    end
    last = fc_eff - FCOUNT_W'(1);
  end

  // --------------------------------------------------------------------------
  // One frame step according to the loop mode and direction.
  // --------------------------------------------------------------------------
  always_comb begin
    logic inc;
    logic below_last;
    logic above_zero;
    inc        = (mode_q == RUN_INC);
    below_last = ({1'b0, frame_q} < last);
    above_zero = (frame_q != '0);
    step_frame = frame_q;
    step_mode  = mode_q;
    case (wrap_mode_q)
      LOOP_PING: begin
        if (inc) begin
          if (below_last) begin
            step_frame = frame_q + FRAME_W'(1);
          end else begin
            if (above_zero) step_frame = frame_q - FRAME_W'(1);
            step_mode = RUN_DEC;
          end
        end else begin
          if (above_zero) begin
            step_frame = frame_q - FRAME_W'(1);
          end else begin
            if (below_last) step_frame = frame_q + FRAME_W'(1);
            step_mode = RUN_INC;
          end
        end
      end
      LOOP_REPEAT: begin
        if (inc) begin
          step_frame = below_last ? frame_q + FRAME_W'(1) : '0;
        end else begin
          step_frame = above_zero ? frame_q - FRAME_W'(1) : FRAME_W'(last);
        end
      end
      default: begin
        // stop at end, and the unused mode code
        if (inc) begin
          if (below_last) step_frame = frame_q + FRAME_W'(1);
          else            step_mode  = RUN_PAUSED;
        end else begin
          if (above_zero) step_frame = frame_q - FRAME_W'(1);
          else            step_mode  = RUN_PAUSED;
        end
      end
    endcase
  end

  // Saturating add of the scaled tick increment (8.8 gain, drop the fraction).
  assign sum    = {1'b0, accum_q} + {9'd0, prod_q[ACCUM_W-1:8]};
  assign cmd_ok = (priority_req_i >= prio_q) || (mode_q == RUN_PAUSED);

  // Load the result register when a result is ready and the slot is free.
  assign out_load = (state_q == S_RES) && (!out_valid_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    accum_d   = accum_q;
    frame_d   = frame_q;
    mode_d    = mode_q;
    resume_d  = resume_q;
    prio_d    = prio_q;
    speed_d   = speed_q;
    applied_d = applied_q;
    cnt_d     = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          applied_d = 1'b0;
          cnt_d     = '0;
          state_d   = S_RES;
          case (req_type_i)
            REQ_TICK: begin
              // a paused sequencer ignores time
              if (mode_q != RUN_PAUSED) state_d = S_ADD;
            end
            REQ_CMD: begin
              if (cmd_ok) begin
                applied_d = 1'b1;
                prio_d    = priority_req_i;
                if (speed_change_i) speed_d = new_speed_i;
                case (command_i)
                  CMD_PAUSE: begin
                    if (mode_q != RUN_PAUSED) begin
                      resume_d = mode_q;
                      mode_d   = RUN_PAUSED;
                    end
                  end
                  CMD_STOP: begin
                    resume_d = RUN_INC;
                    mode_d   = RUN_PAUSED;
                    frame_d  = '0;
                    accum_d  = '0;
                  end
                  CMD_START: begin
                    mode_d  = RUN_INC;
                    frame_d = '0;
                    accum_d = '0;
                  end
                  CMD_CONTINUE: begin
                    if (mode_q == RUN_PAUSED) mode_d = resume_q;
                  end
                  default: ;
                endcase
              end
            end
            default: ;  // loads go to the RAM; unknown requests do nothing
          endcase
        end
      end
      S_ADD: begin
        accum_d = sum[ACCUM_W] ? '1 : sum[ACCUM_W-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if ((mode_q == RUN_PAUSED) || (cnt_q == CNT_W'(MAX_ADVANCE)) ||
            (accum_q <= {8'd0, dur})) begin
          state_d = S_RES;
        end else begin
          accum_d = accum_q - {8'd0, dur};
          frame_d = step_frame;
          mode_d  = step_mode;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_RD;
        end
      end
      S_RD: begin
        // wait for the duration of the new frame
        state_d = S_CMP;
      end
      S_RES: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wrap_mode_q   <= LOOP_REPEAT;
      frame_count_q <= FCOUNT_W'(1);
      accum_q       <= '0;
      frame_q       <= '0;
      mode_q        <= RUN_PAUSED;
      resume_q      <= RUN_INC;
      prio_q        <= '0;
      speed_q       <= SPEED_W'(256);
      applied_q     <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      accum_q   <= accum_d;
      frame_q   <= frame_d;
      mode_q    <= mode_d;
      resume_q  <= resume_d;
      prio_q    <= prio_d;
      speed_q   <= speed_d;
      applied_q <= applied_d;
      cnt_q     <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WRAP_MODE:   wrap_mode_q   <= cfg_data_i[LOOP_W-1:0];
          CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[FCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q <= ACCUM_W'(delta_time_i * speed_q);
    end
    if (out_load) begin
      out_frame_q   <= frame_q;
      out_run_q     <= mode_q;
      out_applied_q <= applied_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign run_state_o   = out_run_q;
  assign applied_o     = out_applied_q;

endmodule

>>> src/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks for the sprite frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_core_defines.svh"

module sfs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sfs_pkg::FRAME_W-1:0] frame_index_o,
  input logic [sfs_pkg::RUN_W-1:0]   run_state_o,
  input logic                        applied_o
);

  import sfs_pkg::*;

  // Hold a stalled result.
  `SFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // Keep a stalled payload steady.
  `SFS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(frame_index_o) && $stable(run_state_o) && $stable(applied_o), "stalled result changed")

  // One request in flight: a taken request closes the input in the next cycle.
  `SFS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")

  // Reported run state is one of the three defined codes.
  `SFS_ASSERT_NOW(a_run_code, clk_i, rst_ni, out_valid_o, (run_state_o == RUN_PAUSED) || (run_state_o == RUN_INC) || (run_state_o == RUN_DEC), "bad run state")

endmodule

bind sprite_frame_sequencer_core sfs_checker u_sfs_checker (.*);
